// ===== rtl/cclp_pkg.sv =====
// Shared types and constants of the clock command line parser.
// No dependencies; imported by cclp_judge, clock_command_line_parser and the testbench.
`default_nettype none

package cclp_pkg;

  localparam int unsigned LineMax = 5;

  localparam logic [2:0] LINE_MAX_CNT  = 3'd5;
  localparam logic [2:0] LINE_OVER_CNT = 3'd6;

  localparam logic [1:0] OP_CABLE = 2'd0;
  localparam logic [1:0] OP_RADIO = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;

  localparam logic [11:0] TICK_MAX      = 12'd4095;
  localparam logic [11:0] SILENCE_RESET = 12'd2100;
  localparam logic [2:0]  CHANNEL_RESET = 3'd1;

  localparam logic CFG_OWN_CHANNEL   = 1'b0;
  localparam logic CFG_SILENCE_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_TIME_SET  = 3'd1,
    EV_HONK      = 3'd2,
    EV_B_OK      = 3'd3,
    EV_REJECT    = 3'd4,
    EV_LINK_LOST = 3'd5
  } event_e;

  typedef logic [LineMax-1:0][7:0] line_t;

  typedef struct packed {
    event_e     ev;
    logic [6:0] new_time;
    logic [3:0] bright;
    logic       time_up;
  } verdict_t;

endpackage

`default_nettype wire

// ===== rtl/cclp_judge.sv =====
// Line checker: matches a finished line against the T and H/B forms.
// Depends on cclp_pkg.
`default_nettype none

module cclp_judge
  import cclp_pkg::*;
(
  input  line_t      line_i,
  input  logic [2:0] len_i,
  input  logic       check_channel_i,
  input  logic [2:0] own_channel_i,
  input  logic [6:0] held_time_i,
  output verdict_t   verdict_o
);

  logic [7:0] last_char;
  logic       chan_ok;
  logic       short_ok;
  logic       long_ok;
  logic [3:0] tens;
  logic [3:0] ones;
  logic [6:0] time_val;

  always_comb begin
    last_char = (len_i == 3'd2) ? line_i[1] : line_i[4];
    chan_ok   = !check_channel_i || (last_char == (CH_ZERO + {5'd0, own_channel_i}));
    short_ok  = (line_i[0] == CH_H || line_i[0] == CH_B) &&
                line_i[1] >= CH_ONE && line_i[1] <= CH_FOUR;
    long_ok   = line_i[0] == CH_T &&
                line_i[1] >= CH_ZERO && line_i[1] <= CH_NINE &&
                line_i[2] >= CH_ZERO && line_i[2] <= CH_NINE &&
                line_i[3] >= CH_ONE  && line_i[3] <= CH_EIGHT &&
                line_i[4] >= CH_ONE  && line_i[4] <= CH_FOUR;
    tens      = line_i[1][3:0];
    ones      = line_i[2][3:0];
    time_val  = ({3'd0, tens} << 3) + ({3'd0, tens} << 1) + {3'd0, ones};

    verdict_o          = '0;
    verdict_o.ev       = EV_REJECT;
    verdict_o.new_time = held_time_i;
    if (chan_ok) begin
      if (len_i == 3'd2 && short_ok) begin
        verdict_o.ev = (line_i[0] == CH_H) ? EV_HONK : EV_B_OK;
      end else if (len_i == LINE_MAX_CNT && long_ok) begin
        verdict_o.ev       = EV_TIME_SET;
        verdict_o.new_time = time_val;
        verdict_o.bright   = line_i[3][3:0];
        verdict_o.time_up  = (time_val == 7'd0) && (held_time_i != 7'd0);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clock_command_line_parser.sv =====
// Top level of the clock command line parser: input stage, line buffers,
// link timer and result register. Depends on cclp_pkg and cclp_judge.
//
// Usage:
//   Requests enter on in_valid_i/in_ready_o with operation_i (cable byte,
//   radio byte or millisecond tick), data_byte_i and packet_end_i. Every
//   request yields exactly one result on out_valid_o/out_ready_i carrying
//   event_res_o, shot_time_o, brightness_o, time_up_o, link_active_o and
//   cable_mode_o.
//   The line check and state update run between the input register and the
//   result register.
//   Throughput is one request per cycle while out_ready_i stays high; a new
//   request is taken while the previous result is still held.
//   When out_ready_i is low the result register holds and the input register
//   fills; in_ready_o then drops until the result is taken.
//   The user must write configuration (cfg_we_i, cfg_index_i, cfg_data_i)
//   only while idle; the block itself does not enforce this. Index 0 is the
//   own channel, index 1 the silence limit.
//   Reset clears counts, link, cable mode, held time and both registers to
//   their defaults (channel 1, silence limit 2100). No clearing pass.
`default_nettype none

module clock_command_line_parser
  import cclp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  data_byte_i,
  input  logic        packet_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_res_o,
  output logic [6:0]  shot_time_o,
  output logic [3:0]  brightness_o,
  output logic        time_up_o,
  output logic        link_active_o,
  output logic        cable_mode_o
);

  logic [2:0]  own_channel_q;
  logic [11:0] silence_limit_q;

  logic        in_valid_q;
  logic [1:0]  op_q;
  logic [7:0]  byte_q;
  logic        pend_q;

  line_t       cable_buf_q;
  line_t       radio_buf_q;
  logic [2:0]  cable_cnt_q, cable_cnt_d;
  logic [2:0]  radio_cnt_q, radio_cnt_d;
  logic        cable_mode_q, cable_mode_d;
  logic        link_q, link_d;
  logic [11:0] ticks_q, ticks_d;
  logic [6:0]  held_q, held_d;

  logic        out_valid_q;
  event_e      ev_q, ev_d;
  logic [3:0]  bright_q, bright_d;
  logic        tup_q, tup_d;

  logic        advance;
  logic        cable_wr;
  logic        radio_wr;
  logic        is_space;
  line_t       radio_line;
  logic [2:0]  radio_len;
  line_t       judge_line;
  logic [2:0]  judge_len;
  verdict_t    verdict;
  logic [11:0] ticks_inc;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign is_space = byte_q == CH_SPACE || byte_q == CH_TAB || byte_q == CH_CR ||
                    byte_q == CH_VT || byte_q == CH_FF;

  always_comb begin
    radio_line = radio_buf_q;
    if (radio_cnt_q < LINE_MAX_CNT) begin
      radio_line[radio_cnt_q] = byte_q;
      radio_len               = radio_cnt_q + 3'd1;
    end else begin
      radio_len = LINE_OVER_CNT;
    end
  end

  assign judge_line = (op_q == OP_CABLE) ? cable_buf_q : radio_line;
  assign judge_len  = (op_q == OP_CABLE) ? cable_cnt_q : radio_len;

  cclp_judge u_judge (
    .line_i          (judge_line),
    .len_i           (judge_len),
    .check_channel_i (op_q == OP_RADIO),
    .own_channel_i   (own_channel_q),
    .held_time_i     (held_q),
    .verdict_o       (verdict)
  );

  assign ticks_inc = (ticks_q < TICK_MAX) ? ticks_q + 12'd1 : ticks_q;

  always_comb begin
    cable_cnt_d  = cable_cnt_q;
    radio_cnt_d  = radio_cnt_q;
    cable_mode_d = cable_mode_q;
    link_d       = link_q;
    ticks_d      = ticks_q;
    held_d       = held_q;
    ev_d         = EV_NONE;
    bright_d     = 4'd0;
    tup_d        = 1'b0;
    cable_wr     = 1'b0;
    radio_wr     = 1'b0;
    case (op_q)
      OP_CABLE: begin
        if (byte_q == CH_NL) begin
          cable_mode_d = 1'b1;
          link_d       = 1'b1;
          ticks_d      = 12'd0;
          cable_cnt_d  = 3'd0;
          ev_d         = verdict.ev;
          bright_d     = verdict.bright;
          tup_d        = verdict.time_up;
          held_d       = verdict.new_time;
        end else if (!is_space) begin
          if (cable_cnt_q < LINE_MAX_CNT) begin
            cable_wr    = 1'b1;
            cable_cnt_d = cable_cnt_q + 3'd1;
          end else begin
            cable_cnt_d = LINE_OVER_CNT;
          end
        end
      end
      OP_RADIO: begin
        if (cable_mode_q) begin
          radio_cnt_d = 3'd0;
        end else begin
          radio_wr    = radio_cnt_q < LINE_MAX_CNT;
          radio_cnt_d = radio_len;
          if (pend_q) begin
            link_d      = 1'b1;
            ticks_d     = 12'd0;
            radio_cnt_d = 3'd0;
            ev_d        = verdict.ev;
            bright_d    = verdict.bright;
            tup_d       = verdict.time_up;
            held_d      = verdict.new_time;
          end
        end
      end
      OP_TICK: begin
        if (link_q) begin
          ticks_d = ticks_inc;
          if (ticks_inc >= silence_limit_q) begin
            link_d       = 1'b0;
            cable_mode_d = 1'b0;
            ev_d         = EV_LINK_LOST;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_channel_q   <= CHANNEL_RESET;
      silence_limit_q <= SILENCE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_OWN_CHANNEL:   own_channel_q   <= cfg_data_i[2:0];
        CFG_SILENCE_LIMIT: silence_limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= operation_i;
      byte_q <= data_byte_i;
      pend_q <= packet_end_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && cable_wr) begin
      cable_buf_q[cable_cnt_q] <= byte_q;
    end
    if (advance && radio_wr) begin
      radio_buf_q[radio_cnt_q] <= byte_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cable_cnt_q  <= 3'd0;
      radio_cnt_q  <= 3'd0;
      cable_mode_q <= 1'b0;
      link_q       <= 1'b0;
      ticks_q      <= 12'd0;
      held_q       <= 7'd0;
      out_valid_q  <= 1'b0;
      ev_q         <= EV_NONE;
      bright_q     <= 4'd0;
      tup_q        <= 1'b0;
    end else if (advance) begin
      cable_cnt_q  <= cable_cnt_d;
      radio_cnt_q  <= radio_cnt_d;
      cable_mode_q <= cable_mode_d;
      link_q       <= link_d;
      ticks_q      <= ticks_d;
      held_q       <= held_d;
      out_valid_q  <= 1'b1;
      ev_q         <= ev_d;
      bright_q     <= bright_d;
      tup_q        <= tup_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = ev_q;
  assign shot_time_o   = held_q;
  assign brightness_o  = bright_q;
  assign time_up_o     = tup_q;
  assign link_active_o = link_q;
  assign cable_mode_o  = cable_mode_q;

endmodule

`default_nettype wire

// ===== dv/clock_command_line_parser_tb.sv =====
// Self-checking testbench for clock_command_line_parser: directed and random requests,
// with results predicted by a scoreboard class. Needs cclp_pkg and the RTL of the
// parser; nothing else.
`timescale 1ns / 100ps

module clock_command_line_parser_tb;
  import cclp_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         MAX_REPORTS = 10;

  typedef struct packed {
    event_e     ev;
    logic [6:0] shot;
    logic [3:0] bright;
    logic       up;
    logic       link;
    logic       cable;
  } parser_result_t;

  class parser_scoreboard;
    logic [2:0]     own_channel;
    logic [11:0]    silence_limit;
    line_t          cable_text;
    line_t          radio_text;
    logic [2:0]     cable_len;
    logic [2:0]     radio_len;
    bit             cable_on;
    bit             link_on;
    logic [11:0]    quiet_ticks;
    logic [6:0]     held_time;
    parser_result_t awaited[$];
    int             mismatches;

    function new();
      own_channel   = CHANNEL_RESET;
      silence_limit = SILENCE_RESET;
      cable_text    = '0;
      radio_text    = '0;
      cable_len     = '0;
      radio_len     = '0;
      cable_on      = 1'b0;
      link_on       = 1'b0;
      quiet_ticks   = '0;
      held_time     = '0;
      mismatches    = 0;
    endfunction

    function void write_register(logic index, logic [11:0] value);
      if (index == CFG_OWN_CHANNEL) begin
        own_channel = value[2:0];
      end else begin
        silence_limit = value;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function bit has_effect(logic [1:0] op);
      return op == OP_CABLE || (op == OP_RADIO && !cable_on) || (op == OP_TICK && link_on);
    endfunction

    function void append_char(inout line_t text, inout logic [2:0] len, input logic [7:0] c);
      if (len < LINE_MAX_CNT) begin
        text[len] = c;
        len = len + 3'd1;
      end else begin
        len = LINE_OVER_CNT;
      end
    endfunction

    function verdict_t grade_line(line_t text, logic [2:0] len, bit need_channel);
      verdict_t   v;
      logic [6:0] prev;
      int         tens;
      int         ones;
      v.ev       = EV_REJECT;
      v.new_time = held_time;
      v.bright   = '0;
      v.time_up  = 1'b0;
      if (len == 3'd0 || len > LINE_MAX_CNT) return v;
      if (need_channel && text[len - 3'd1] != 8'(CH_ZERO + own_channel)) return v;
      if (len == 3'd2) begin
        if ((text[0] == CH_H || text[0] == CH_B) && text[1] >= CH_ONE && text[1] <= CH_FOUR)
          v.ev = (text[0] == CH_H) ? EV_HONK : EV_B_OK;
      end else if (len == LINE_MAX_CNT) begin
        if (text[0] == CH_T && text[1] >= CH_ZERO && text[1] <= CH_NINE &&
            text[2] >= CH_ZERO && text[2] <= CH_NINE && text[3] >= CH_ONE &&
            text[3] <= CH_EIGHT && text[4] >= CH_ONE && text[4] <= CH_FOUR) begin
          prev       = held_time;
          tens       = int'(text[1]) - int'(CH_ZERO);
          ones       = int'(text[2]) - int'(CH_ZERO);
          held_time  = 7'(tens * 10 + ones);
          v.ev       = EV_TIME_SET;
          v.new_time = held_time;
          v.bright   = 4'(text[3] - CH_ZERO);
          v.time_up  = (held_time == 7'd0 && prev != 7'd0);
        end
      end
      return v;
    endfunction

    function void note_request(logic [1:0] op, logic [7:0] c, logic last);
      verdict_t       v;
      parser_result_t r;
      v.ev       = EV_NONE;
      v.new_time = '0;
      v.bright   = '0;
      v.time_up  = 1'b0;
      case (op)
        OP_CABLE: begin
          if (c == CH_NL) begin
            cable_on    = 1'b1;
            link_on     = 1'b1;
            quiet_ticks = '0;
            v           = grade_line(cable_text, cable_len, 1'b0);
            cable_len   = '0;
          end else if (!(c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT ||
                         c == CH_FF)) begin
            append_char(cable_text, cable_len, c);
          end
        end
        OP_RADIO: begin
          if (cable_on) begin
            radio_len = '0;
          end else begin
            append_char(radio_text, radio_len, c);
            if (last) begin
              link_on     = 1'b1;
              quiet_ticks = '0;
              v           = grade_line(radio_text, radio_len, 1'b1);
              radio_len   = '0;
            end
          end
        end
        OP_TICK: begin
          if (link_on) begin
            if (quiet_ticks < TICK_MAX) quiet_ticks = quiet_ticks + 12'd1;
            if (quiet_ticks >= silence_limit) begin
              link_on  = 1'b0;
              cable_on = 1'b0;
              v.ev     = EV_LINK_LOST;
            end
          end
        end
        default: ;
      endcase
      r.ev     = v.ev;
      r.shot   = held_time;
      r.bright = v.bright;
      r.up     = v.time_up;
      r.link   = link_on;
      r.cable  = cable_on;
      awaited.push_back(r);
    endfunction

    function void check_result(parser_result_t got);
      parser_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: ev=%0d time=%0d bright=%0d up=%0b link=%0b cable=%0b",
                   got.ev, got.shot, got.bright, got.up, got.link, got.cable);
        return;
      end
      want = awaited.pop_front();
      if (got.ev !== want.ev || got.shot !== want.shot || got.bright !== want.bright ||
          got.up !== want.up || got.link !== want.link || got.cable !== want.cable) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected ev=%0d time=%0d bright=%0d up=%0b link=%0b cable=%0b, %s",
                   want.ev, want.shot, want.bright, want.up, want.link, want.cable,
                   $sformatf("got ev=%0d time=%0d bright=%0d up=%0b link=%0b cable=%0b",
                             got.ev, got.shot, got.bright, got.up, got.link, got.cable));
      end
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic        cfg_index_i  = CFG_OWN_CHANNEL;
  logic [11:0] cfg_data_i   = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i  = OP_TICK;
  logic [7:0]  data_byte_i  = '0;
  logic        packet_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [2:0]  event_res_o;
  logic [6:0]  shot_time_o;
  logic [3:0]  brightness_o;
  logic        time_up_o;
  logic        link_active_o;
  logic        cable_mode_o;

  parser_scoreboard parser_sb = new();
  int               effective_items = 0;
  int               cycle_count = 0;
  bit               calm = 1'b0;
  logic [2:0]       channel_cfg = CHANNEL_RESET;
  logic [11:0]      limit_cfg = SILENCE_RESET;
  logic [7:0]       line_buf[$];

  clock_command_line_parser DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .data_byte_i  (data_byte_i),
    .packet_end_i (packet_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_res_o  (event_res_o),
    .shot_time_o  (shot_time_o),
    .brightness_o (brightness_o),
    .time_up_o    (time_up_o),
    .link_active_o(link_active_o),
    .cable_mode_o (cable_mode_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 22);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      parser_sb.check_result({event_res_o, shot_time_o, brightness_o, time_up_o,
                              link_active_o, cable_mode_o});
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [7:0] c, input logic last);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    data_byte_i  <= c;
    packet_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    if (parser_sb.has_effect(op)) effective_items++;
    parser_sb.note_request(op, c, last);
  endtask

  task automatic send_text(input logic [1:0] op, input string s, input bit close);
    for (int i = 0; i < s.len(); i++) send_request(op, s[i], close && i == s.len() - 1);
  endtask

  task automatic go_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (parser_sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic configure(input logic [2:0] channel, input logic [11:0] limit);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_OWN_CHANNEL;
    cfg_data_i  <= {9'd0, channel};
    @(negedge clk_i);
    cfg_index_i <= CFG_SILENCE_LIMIT;
    cfg_data_i  <= limit;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    parser_sb.write_register(CFG_OWN_CHANNEL, {9'd0, channel});
    parser_sb.write_register(CFG_SILENCE_LIMIT, limit);
    channel_cfg = channel;
    limit_cfg   = limit;
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      3: return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  // build a command in line_buf; a broken one loses, gains or corrupts a character
  task automatic make_command(input bit broken);
    logic [7:0] chan;
    int         kind;
    int         pos;
    chan = ($urandom_range(99) < 80) ? 8'(CH_ZERO + channel_cfg)
                                     : 8'($urandom_range(CH_ONE, CH_FOUR));
    kind = $urandom_range(99);
    line_buf.delete();
    if (kind < 50) begin
      line_buf.push_back(CH_T);
      if ($urandom_range(99) < 15) begin
        line_buf.push_back(CH_ZERO);
        line_buf.push_back(CH_ZERO);
      end else begin
        line_buf.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        line_buf.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
      end
      line_buf.push_back(8'($urandom_range(CH_ONE, CH_EIGHT)));
    end else begin
      line_buf.push_back((kind < 75) ? CH_H : CH_B);
    end
    line_buf.push_back(chan);
    if (broken) begin
      pos = $urandom_range(line_buf.size() - 1);
      case ($urandom_range(3))
        0: line_buf.delete(pos);
        1: repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        2: line_buf[pos] = 8'($urandom_range(255));
        default: line_buf[pos] = 8'($urandom_range(CH_B, CH_T));
      endcase
    end
  endtask

  task automatic send_radio_line(input bit close);
    foreach (line_buf[i]) send_request(OP_RADIO, line_buf[i], close && i == line_buf.size() - 1);
  endtask

  task automatic send_cable_line();
    foreach (line_buf[i]) begin
      if ($urandom_range(99) < 20) send_request(OP_CABLE, pick_blank(), 1'($urandom_range(1)));
      send_request(OP_CABLE, line_buf[i], 1'($urandom_range(1)));
    end
    send_request(OP_CABLE, CH_NL, 1'($urandom_range(1)));
  endtask

  task automatic random_phase(input int goal);
    int start;
    int pick;
    int cap;
    start = effective_items;
    while (effective_items - start < goal) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        make_command(1'b0);
        send_radio_line(1'b1);
      end else if (pick < 60) begin
        make_command(1'b0);
        send_cable_line();
      end else if (pick < 78) begin
        cap = (limit_cfg < 12'd30) ? int'(limit_cfg) + 2 : 30;
        repeat ($urandom_range(1, cap))
          send_request(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (pick < 90) begin
        make_command(1'b1);
        if ($urandom_range(1) == 0) send_radio_line($urandom_range(3) != 0);
        else send_cable_line();
      end else begin
        send_request(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic run_phase(input logic [2:0] channel, input logic [11:0] limit, input int goal);
    go_quiet();
    wait_drained();
    configure(channel, limit);
    random_phase(goal);
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: no link yet, then radio lines, cable lines and overlong input
    send_request(OP_TICK, 8'hFF, 1'b1);
    send_request(OP_UNUSED, 8'h00, 1'b0);
    send_text(OP_RADIO, "T9981", 1'b1);
    send_text(OP_RADIO, "T0011", 1'b1);
    send_text(OP_RADIO, "H", 1'b1);
    send_request(OP_CABLE, CH_SPACE, 1'b0);
    send_text(OP_CABLE, "B", 1'b0);
    send_request(OP_CABLE, CH_TAB, 1'b1);
    send_text(OP_CABLE, "4", 1'b0);
    send_request(OP_CABLE, CH_CR, 1'b0);
    send_request(OP_CABLE, CH_VT, 1'b0);
    send_request(OP_CABLE, CH_FF, 1'b0);
    send_request(OP_CABLE, CH_NL, 1'b1);
    send_text(OP_RADIO, "H", 1'b1);
    send_request(OP_CABLE, CH_NL, 1'b0);
    send_text(OP_CABLE, "T9981", 1'b0);
    send_request(OP_CABLE, 8'h80, 1'b0);
    send_request(OP_CABLE, CH_NL, 1'b0);

    run_phase(3'd4, 12'd1, 80);
    run_phase(3'd0, 12'd0, 50);

    // keep the link up through a run of ticks at the largest limit
    go_quiet();
    wait_drained();
    configure(3'd7, TICK_MAX);
    send_request(OP_CABLE, CH_NL, 1'b0);
    repeat (30) send_request(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
    random_phase(50);

    go_quiet();
    wait_drained();
    configure(3'd2, 12'd20);
    calm = 1'b1;
    random_phase(60);
    calm = 1'b0;
    random_phase(60);

    run_phase(3'd3, 12'd7, 110);
    run_phase(3'd5, 12'd3, 30);
    run_phase(CHANNEL_RESET, SILENCE_RESET, 50);

    go_quiet();
    wait_drained();
    repeat (8) @(negedge clk_i);
    if (parser_sb.mismatches == 0 && parser_sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
